/* src/fcfl_pkg.sv */
// ----------------------------------------------------------------------------
// fcfl_pkg
// shared types and constants of the fixed chunk free list allocator
// ----------------------------------------------------------------------------
package fcfl_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W = 32;
    localparam int SHIFT_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_CHUNK = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

endpackage

/* src/fcfl_ram.sv */
// ----------------------------------------------------------------------------
// fcfl_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module fcfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fcfl_ctrl.sv */
// ----------------------------------------------------------------------------
// fcfl_ctrl
// request sequencing and result handshake of the allocator
// ----------------------------------------------------------------------------
module fcfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output fcfl_pkg::t_dp_cmd o_cmd
);
    import fcfl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.commit = 1'b0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* src/fcfl_dp.sv */
// ----------------------------------------------------------------------------
// fcfl_dp
// free list state, link memory, address arithmetic and result register
// ----------------------------------------------------------------------------
module fcfl_dp #(
    parameter int SLAB_BYTES = 4096,
    parameter int MAX_CHUNKS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcfl_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_cfg_we,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fcfl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_req_cmd,
    input  logic [fcfl_pkg::ADDR_W-1:0]         i_addr,
    output logic [fcfl_pkg::STATUS_W-1:0]       o_status,
    output logic [fcfl_pkg::ADDR_W-1:0]         o_chunk_addr,
    output logic                                o_in_range,
    output logic                                o_all_free
);
    import fcfl_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam logic [ADDR_W-1:0] SLAB_SIZE = ADDR_W'(SLAB_BYTES);
    localparam logic [ADDR_W-1:0] MAX_SIZE = ADDR_W'(MAX_CHUNKS);

    function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] r;
        r = s;
        if (s < SHIFT_MIN) begin
            r = SHIFT_MIN;
        end else if (s > SHIFT_MAX) begin
            r = SHIFT_MAX;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] chunk_total(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] e;
        logic [ADDR_W-1:0]  n;
        e = eff_shift(s);
        n = (SLAB_SIZE + (ADDR_W'(1) << e) - ADDR_W'(1)) >> e;
        if (n > MAX_SIZE) begin
            n = MAX_SIZE;
        end
        return n[CNT_W-1:0];
    endfunction

    // configuration and list state
    logic [SHIFT_W-1:0] r_shift;
    logic [ADDR_W-1:0]  r_base;
    logic [CNT_W-1:0]   r_total;
    logic [IDX_W-1:0]   r_head;
    logic               r_nonempty;
    logic [COUNT_W-1:0] r_list_len;
    logic [CNT_W-1:0]   r_untouched;
    logic [COUNT_W-1:0] r_free_count;

    logic [IDX_W-1:0]   n_head;
    logic               n_nonempty;
    logic [COUNT_W-1:0] n_list_len;
    logic [CNT_W-1:0]   n_untouched;
    logic [COUNT_W-1:0] n_free_count;

    // latched request
    logic               r_cmd;
    logic [ADDR_W:0]    r_diff;

    // result
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]   r_chunk_addr;
    logic                r_in_range;
    logic                r_all_free;
    logic [STATUS_W-1:0] n_status;
    logic [ADDR_W-1:0]   n_chunk_addr;

    logic [SHIFT_W-1:0] shift;
    logic               in_range;
    logic [ADDR_W-1:0]  free_idx;
    logic               free_ok;
    logic [CNT_W-1:0]   untouched_dec;
    logic [IDX_W-1:0]   alloc_idx;
    logic               got;
    logic [IDX_W-1:0]   link_rdata;
    logic               ram_we;

    assign shift = eff_shift(r_shift);
    assign in_range = !r_diff[ADDR_W] && (r_diff[ADDR_W-1:0] < SLAB_SIZE);
    assign free_idx = r_diff[ADDR_W-1:0] >> shift;
    assign free_ok = in_range && (free_idx < ADDR_W'(r_total));
    assign untouched_dec = r_untouched - CNT_W'(1);
    assign ram_we = i_cmd.commit && (r_cmd == CMD_FREE) && free_ok;

    fcfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_CHUNKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_idx[IDX_W-1:0]),
        .i_wdata (r_head),
        .i_re    (i_cmd.load),
        .i_raddr (r_head),
        .o_rdata (link_rdata)
    );

    always_comb begin
        n_head = r_head;
        n_nonempty = r_nonempty;
        n_list_len = r_list_len;
        n_untouched = r_untouched;
        n_free_count = r_free_count;
        n_status = STAT_OK;
        n_chunk_addr = '0;
        alloc_idx = r_head;
        got = 1'b0;
        if (r_cmd == CMD_ALLOC) begin
            priority if (r_nonempty) begin
                got = 1'b1;
                alloc_idx = r_head;
                n_head = link_rdata;
                if (r_list_len != '0) begin
                    n_list_len = r_list_len - COUNT_W'(1);
                end
                n_nonempty = (n_list_len != '0);
            end else if (r_untouched != '0) begin
                got = 1'b1;
                n_untouched = untouched_dec;
                alloc_idx = untouched_dec[IDX_W-1:0];
            end else begin
                got = 1'b0;
            end
            if (got) begin
                n_chunk_addr = r_base + (ADDR_W'(alloc_idx) << shift);
                if (r_free_count != '0) begin
                    n_free_count = r_free_count - COUNT_W'(1);
                end
            end else begin
                n_status = STAT_NO_CHUNK;
            end
        end else begin
            if (free_ok) begin
                n_head = free_idx[IDX_W-1:0];
                n_nonempty = 1'b1;
                if (r_list_len != '1) begin
                    n_list_len = r_list_len + COUNT_W'(1);
                end
                if (r_free_count != '1) begin
                    n_free_count = r_free_count + COUNT_W'(1);
                end
            end else begin
                n_status = STAT_IGNORED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_base <= '0;
            r_total <= chunk_total(SHIFT_RESET);
            r_head <= '0;
            r_nonempty <= 1'b0;
            r_list_len <= '0;
            r_untouched <= chunk_total(SHIFT_RESET);
            r_free_count <= COUNT_W'(chunk_total(SHIFT_RESET));
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CHUNK_SHIFT) begin
                r_shift <= i_cfg_data[SHIFT_W-1:0];
                r_total <= chunk_total(i_cfg_data[SHIFT_W-1:0]);
                r_head <= '0;
                r_nonempty <= 1'b0;
                r_list_len <= '0;
                r_untouched <= chunk_total(i_cfg_data[SHIFT_W-1:0]);
                r_free_count <= COUNT_W'(chunk_total(i_cfg_data[SHIFT_W-1:0]));
            end else begin
                r_base <= i_cfg_data[ADDR_W-1:0];
            end
        end else if (i_cmd.commit) begin
            r_head <= n_head;
            r_nonempty <= n_nonempty;
            r_list_len <= n_list_len;
            r_untouched <= n_untouched;
            r_free_count <= n_free_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd;
            r_diff <= {1'b0, i_addr} - {1'b0, r_base};
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_chunk_addr <= n_chunk_addr;
            r_in_range <= in_range;
            r_all_free <= (n_free_count == COUNT_W'(r_total));
        end
    end

    assign o_status = r_status;
    assign o_chunk_addr = r_chunk_addr;
    assign o_in_range = r_in_range;
    assign o_all_free = r_all_free;

endmodule

/* src/fixed_chunk_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator
// slab allocator handing out fixed size chunks from a last-in-first-out list
// ----------------------------------------------------------------------------
// In the cycle a request is accepted the link of the current list head is
// read from the link ram; in the exec state that follows, the list state is
// updated and the result is loaded into the output register. A new request
// is accepted while a result still waits in the output register; the exec
// state of a request waits only while that register is full and stalled.
// The link ram needs no clearing pass, so the block is ready right after
// reset. Writing chunk_shift empties the list and marks all chunks free.
module fixed_chunk_free_list_allocator #(
    parameter int SLAB_BYTES = 4096,
    parameter int MAX_CHUNKS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fcfl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [fcfl_pkg::ADDR_W-1:0]         i_addr,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [fcfl_pkg::STATUS_W-1:0]       o_status,
    output logic [fcfl_pkg::ADDR_W-1:0]         o_chunk_addr,
    output logic                                o_in_range,
    output logic                                o_all_free
);
    import fcfl_pkg::*;

    t_dp_cmd dp_cmd;

    fcfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    fcfl_dp #(
        .SLAB_BYTES (SLAB_BYTES),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_cmd    (i_cmd),
        .i_addr       (i_addr),
        .o_status     (o_status),
        .o_chunk_addr (o_chunk_addr),
        .o_in_range   (o_in_range),
        .o_all_free   (o_all_free)
    );

endmodule
